// ===== src/srrip_pkg.sv =====
`timescale 1ns / 1ps

package srrip_pkg;

  localparam int unsigned IDX_W       = 11;
  localparam int unsigned WAY_IN_W    = 4;
  localparam int unsigned ADDR_W      = 64;
  localparam int unsigned BLOCK_SHIFT = 6;
  localparam int unsigned BLOCK_W     = 32;
  localparam int unsigned META_W      = BLOCK_W + 2;
  localparam int unsigned RED_SHIFT   = 24;
  localparam int unsigned NSET_W      = 17;
  localparam int unsigned PROD_W      = IDX_W + RED_SHIFT + 1;
  localparam int unsigned QN_W        = IDX_W + NSET_W;

  localparam logic [1:0] AGE_MAX  = 2'd3;
  localparam logic [1:0] AGE_MID  = 2'd2;
  localparam logic [1:0] AGE_NEAR = 2'd0;
  localparam logic [1:0] CTR_MAX  = 2'd3;
  localparam logic [1:0] CTR_MIN  = 2'd0;
  localparam logic [1:0] CTR_INIT = 2'd1;

  localparam logic FUNC_QUERY  = 1'b0;
  localparam logic FUNC_UPDATE = 1'b1;

  typedef struct packed {
    logic clear;
    logic capture;
    logic red1;
    logic red2;
    logic red3;
    logic read;
    logic eval;
    logic vq;
    logic mdec;
    logic mrd;
    logic mfin;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic func;
    logic hit;
    logic clr_last;
  } sts_t;

endpackage

// ===== src/ship_rrip_streaming_replacement_core.sv =====
`timescale 1ns / 1ps
// Channel | Direction | Handshake               | Payload
// in      | input     | in_valid_i, in_stall_o   | func_i, set_index_i, way_i, phys_addr_i, pc_i,
//         |           |                          | hit_i
// out     | output    | out_valid_o, out_stall_i | victim_way_o
//
// One transaction is handled at a time: after acceptance it passes the three-step set index
// reduction and the registered RAM reads; a query then adds VQ, a miss update MDEC, MRD and
// MFIN, and a hit update none. The next transaction is taken once the result is loaded.
// After reset a clearing pass over max(NUM_SETS, 2**SIG_BITS) addresses (2048 by default)
// initializes every RAM row, and no input transaction is accepted until it is done.
// A finished result waits in the output register while the next transaction is taken in.

module ship_rrip_streaming_replacement_core
  import srrip_pkg::*;
#(
  parameter int unsigned NUM_SETS = 2048,
  parameter int unsigned NUM_WAYS = 16,
  parameter int unsigned SIG_BITS = 6
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                func_i,
  input  logic [IDX_W-1:0]    set_index_i,
  input  logic [WAY_IN_W-1:0] way_i,
  input  logic [ADDR_W-1:0]   phys_addr_i,
  input  logic [ADDR_W-1:0]   pc_i,
  input  logic                hit_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [WAY_IN_W-1:0] victim_way_o
);

  cmd_t cmd;
  sts_t sts;

  srrip_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  srrip_dp #(
    .NUM_SETS (NUM_SETS),
    .NUM_WAYS (NUM_WAYS),
    .SIG_BITS (SIG_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .func_i       (func_i),
    .set_index_i  (set_index_i),
    .way_i        (way_i),
    .phys_addr_i  (phys_addr_i),
    .pc_i         (pc_i),
    .hit_i        (hit_i),
    .victim_way_o (victim_way_o)
  );

endmodule

// ===== src/srrip_ram.sv =====
`timescale 1ns / 1ps

module srrip_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  input  logic                                      re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/srrip_ctrl.sv =====
`timescale 1ns / 1ps

module srrip_ctrl
  import srrip_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_RED1,
    S_RED2,
    S_RED3,
    S_READ,
    S_EVAL,
    S_VQ,
    S_MDEC,
    S_MRD,
    S_MFIN,
    S_OUT
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    cmd_o       = '0;
    state_d     = state_q;
    out_valid_d = out_valid_q & out_stall_i;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (sts_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_RED1;
        end
      end
      S_RED1: begin
        cmd_o.red1 = 1'b1;
        state_d    = S_RED2;
      end
      S_RED2: begin
        cmd_o.red2 = 1'b1;
        state_d    = S_RED3;
      end
      S_RED3: begin
        cmd_o.red3 = 1'b1;
        state_d    = S_READ;
      end
      S_READ: begin
        cmd_o.read = 1'b1;
        state_d    = S_EVAL;
      end
      S_EVAL: begin
        cmd_o.eval = 1'b1;
        if (sts_i.func == FUNC_QUERY) begin
          state_d = S_VQ;
        end else if (sts_i.hit) begin
          state_d = S_OUT;
        end else begin
          state_d = S_MDEC;
        end
      end
      S_VQ: begin
        cmd_o.vq = 1'b1;
        state_d  = S_OUT;
      end
      S_MDEC: begin
        cmd_o.mdec = 1'b1;
        state_d    = S_MRD;
      end
      S_MRD: begin
        cmd_o.mrd = 1'b1;
        state_d   = S_MFIN;
      end
      S_MFIN: begin
        cmd_o.mfin = 1'b1;
        state_d    = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ===== src/srrip_dp.sv =====
`timescale 1ns / 1ps

module srrip_dp
  import srrip_pkg::*;
#(
  parameter int unsigned NUM_SETS = 2048,
  parameter int unsigned NUM_WAYS = 16,
  parameter int unsigned SIG_BITS = 6
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cmd_t                cmd_i,
  output sts_t                sts_o,
  input  logic                func_i,
  input  logic [IDX_W-1:0]    set_index_i,
  input  logic [WAY_IN_W-1:0] way_i,
  input  logic [ADDR_W-1:0]   phys_addr_i,
  input  logic [ADDR_W-1:0]   pc_i,
  input  logic                hit_i,
  output logic [WAY_IN_W-1:0] victim_way_o
);

  localparam int unsigned SET_W     = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int unsigned WAY_W     = $clog2(NUM_WAYS);
  localparam int unsigned SIG_COUNT = 1 << SIG_BITS;
  localparam int unsigned CLR_N     = (NUM_SETS > SIG_COUNT) ? NUM_SETS : SIG_COUNT;
  localparam int unsigned CLR_W     = $clog2(CLR_N);
  localparam int unsigned AROW_W    = NUM_WAYS * 2;
  localparam int unsigned SROW_W    = NUM_WAYS * SIG_BITS;
  localparam int unsigned MUL_I     = (1 << RED_SHIFT) / NUM_SETS;
  localparam logic [RED_SHIFT:0] MUL = (RED_SHIFT + 1)'(MUL_I);
  localparam logic [NSET_W-1:0] NSETS = NSET_W'(NUM_SETS);

  logic [WAY_W-1:0] way_map [2**WAY_IN_W];

  for (genvar gi = 0; gi < 2**WAY_IN_W; gi++) begin : g_way_map
    localparam int unsigned WR = gi % NUM_WAYS;
    assign way_map[gi] = WAY_W'(WR);
  end

  logic                func_q, hit_q;
  logic [IDX_W-1:0]    idx_q;
  logic [WAY_W-1:0]    way_q;
  logic [BLOCK_W-1:0]  block_q;
  logic [SIG_BITS-1:0] sig_q, old_q;
  logic [PROD_W-1:0]   prod_q;
  logic [QN_W-1:0]     qn_q;
  logic [SET_W-1:0]    set_q;
  logic [1:0]          max_q;
  logic                dead_q;
  logic [WAY_W-1:0]    vict_q;
  logic [WAY_IN_W-1:0] victim_q;
  logic [CLR_W-1:0]    clr_q;

  logic [QN_W-1:0]     rem_full, rem_adj;
  logic [IDX_W-1:0]    quot;

  logic [AROW_W-1:0]   age_rd, age_wdata, age_hit_row, age_miss_row, age_vq_row;
  logic [SROW_W-1:0]   sig_rd, sig_wdata, sig_miss_row;
  logic [META_W-1:0]   meta_rd, meta_wdata;
  logic [1:0]          ctr_rd, ctr_wdata;
  logic                age_we, sig_we, meta_we, ctr_we, ctr_re;
  logic [SET_W-1:0]    set_waddr;
  logic [SIG_BITS-1:0] ctr_waddr, ctr_raddr, old_sig;

  logic                clr_set_ok, clr_ctr_ok;
  logic                any3, any2, any1;
  logic [1:0]          max_d, inc, miss_age;
  logic [WAY_W-1:0]    first_max;
  logic [WAY_W-1:0]    vict_d;
  logic [BLOCK_W-1:0]  delta;
  logic                stream_old, seen_old, stream_new;

  assign quot     = prod_q[RED_SHIFT +: IDX_W];
  assign rem_full = QN_W'(idx_q) - qn_q;
  assign rem_adj  = (rem_full >= QN_W'(NSETS)) ? (rem_full - QN_W'(NSETS)) : rem_full;

  assign old_sig    = sig_rd[way_q * SIG_BITS +: SIG_BITS];
  assign stream_old = meta_rd[BLOCK_W + 1];
  assign seen_old   = meta_rd[BLOCK_W];
  assign delta      = block_q - meta_rd[BLOCK_W-1:0];

  always_comb begin
    stream_new = stream_old;
    if (seen_old) begin
      if (delta == BLOCK_W'(1) || delta == {BLOCK_W{1'b1}}) begin
        stream_new = 1'b1;
      end else if (delta != '0) begin
        stream_new = 1'b0;
      end
    end
  end

  always_comb begin
    any3 = 1'b0;
    any2 = 1'b0;
    any1 = 1'b0;
    for (int i = 0; i < NUM_WAYS; i++) begin
      any3 = any3 | (age_rd[i*2 +: 2] == 2'd3);
      any2 = any2 | (age_rd[i*2 +: 2] == 2'd2);
      any1 = any1 | (age_rd[i*2 +: 2] == 2'd1);
    end
    if (any3) begin
      max_d = 2'd3;
    end else if (any2) begin
      max_d = 2'd2;
    end else if (any1) begin
      max_d = 2'd1;
    end else begin
      max_d = 2'd0;
    end
  end

  always_comb begin
    first_max = '0;
    for (int i = NUM_WAYS - 1; i >= 0; i--) begin
      if (age_rd[i*2 +: 2] == max_q) begin
        first_max = WAY_W'(i);
      end
    end
    if (dead_q) begin
      inc    = (max_q == AGE_MAX) ? 2'd0 : 2'd1;
      vict_d = (max_q[1]) ? first_max : '0;
    end else begin
      inc    = AGE_MAX - max_q;
      vict_d = first_max;
    end
    for (int i = 0; i < NUM_WAYS; i++) begin
      age_vq_row[i*2 +: 2] = age_rd[i*2 +: 2] + inc;
    end
  end

  always_comb begin
    if (ctr_rd == CTR_MIN) begin
      miss_age = AGE_MAX;
    end else if (ctr_rd == CTR_MAX) begin
      miss_age = AGE_NEAR;
    end else begin
      miss_age = AGE_MID;
    end
    age_hit_row                      = age_rd;
    age_hit_row[{way_q, 1'b0} +: 2]  = AGE_NEAR;
    age_miss_row                     = age_rd;
    age_miss_row[{way_q, 1'b0} +: 2] = miss_age;
    sig_miss_row                     = sig_rd;
    sig_miss_row[way_q * SIG_BITS +: SIG_BITS] = sig_q;
  end

  assign clr_set_ok = ({1'b0, clr_q} < (CLR_W + 1)'(NUM_SETS));
  assign clr_ctr_ok = ({1'b0, clr_q} < (CLR_W + 1)'(SIG_COUNT));

  always_comb begin
    age_we     = 1'b0;
    sig_we     = 1'b0;
    meta_we    = 1'b0;
    ctr_we     = 1'b0;
    ctr_re     = 1'b0;
    set_waddr  = set_q;
    age_wdata  = age_rd;
    sig_wdata  = sig_rd;
    meta_wdata = meta_rd;
    ctr_waddr  = sig_q;
    ctr_wdata  = ctr_rd;
    ctr_raddr  = sig_q;
    if (cmd_i.clear) begin
      age_we     = clr_set_ok;
      sig_we     = clr_set_ok;
      meta_we    = clr_set_ok;
      ctr_we     = clr_ctr_ok;
      set_waddr  = clr_q[SET_W-1:0];
      ctr_waddr  = clr_q[SIG_BITS-1:0];
      age_wdata  = {NUM_WAYS{AGE_MAX}};
      sig_wdata  = '0;
      meta_wdata = '0;
      ctr_wdata  = CTR_INIT;
    end
    if (cmd_i.read) begin
      ctr_re = 1'b1;
    end
    if (cmd_i.eval && func_q == FUNC_UPDATE) begin
      meta_we    = 1'b1;
      meta_wdata = {stream_new, 1'b1, block_q};
      if (hit_q) begin
        ctr_we    = (ctr_rd != CTR_MAX);
        ctr_wdata = ctr_rd + 2'd1;
        age_we    = 1'b1;
        age_wdata = age_hit_row;
      end else begin
        ctr_re    = 1'b1;
        ctr_raddr = old_sig;
      end
    end
    if (cmd_i.vq) begin
      age_we    = 1'b1;
      age_wdata = age_vq_row;
    end
    if (cmd_i.mdec) begin
      ctr_we    = (ctr_rd != CTR_MIN);
      ctr_waddr = old_q;
      ctr_wdata = ctr_rd - 2'd1;
    end
    if (cmd_i.mrd) begin
      ctr_re = 1'b1;
    end
    if (cmd_i.mfin) begin
      age_we    = 1'b1;
      age_wdata = age_miss_row;
      sig_we    = 1'b1;
      sig_wdata = sig_miss_row;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      func_q   <= func_i;
      hit_q    <= hit_i;
      idx_q    <= set_index_i;
      way_q    <= way_map[way_i];
      block_q  <= phys_addr_i[BLOCK_SHIFT +: BLOCK_W];
      sig_q    <= pc_i[SIG_BITS-1:0] ^ phys_addr_i[BLOCK_SHIFT +: SIG_BITS];
      vict_q   <= '0;
    end
    if (cmd_i.red1) begin
      prod_q <= PROD_W'(idx_q) * PROD_W'(MUL);
    end
    if (cmd_i.red2) begin
      qn_q <= QN_W'(quot) * QN_W'(NSETS);
    end
    if (cmd_i.red3) begin
      set_q <= SET_W'(rem_adj);
    end
    if (cmd_i.eval) begin
      max_q  <= max_d;
      dead_q <= stream_old && (ctr_rd == CTR_MIN);
      old_q  <= old_sig;
    end
    if (cmd_i.vq) begin
      vict_q <= vict_d;
    end
    if (cmd_i.load_out) begin
      victim_q <= (func_q == FUNC_UPDATE) ? '0 : WAY_IN_W'(vict_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clear) begin
      clr_q <= clr_q + CLR_W'(1);
    end
  end

  srrip_ram #(.WIDTH(AROW_W), .DEPTH(NUM_SETS)) u_age_ram (
    .clk_i   (clk_i),
    .we_i    (age_we),
    .waddr_i (set_waddr),
    .wdata_i (age_wdata),
    .re_i    (cmd_i.read),
    .raddr_i (set_q),
    .rdata_o (age_rd)
  );

  srrip_ram #(.WIDTH(SROW_W), .DEPTH(NUM_SETS)) u_sig_ram (
    .clk_i   (clk_i),
    .we_i    (sig_we),
    .waddr_i (set_waddr),
    .wdata_i (sig_wdata),
    .re_i    (cmd_i.read),
    .raddr_i (set_q),
    .rdata_o (sig_rd)
  );

  srrip_ram #(.WIDTH(META_W), .DEPTH(NUM_SETS)) u_meta_ram (
    .clk_i   (clk_i),
    .we_i    (meta_we),
    .waddr_i (set_waddr),
    .wdata_i (meta_wdata),
    .re_i    (cmd_i.read),
    .raddr_i (set_q),
    .rdata_o (meta_rd)
  );

  srrip_ram #(.WIDTH(2), .DEPTH(SIG_COUNT)) u_ctr_ram (
    .clk_i   (clk_i),
    .we_i    (ctr_we),
    .waddr_i (ctr_waddr),
    .wdata_i (ctr_wdata),
    .re_i    (ctr_re),
    .raddr_i (ctr_raddr),
    .rdata_o (ctr_rd)
  );

  assign sts_o.func     = func_q;
  assign sts_o.hit      = hit_q;
  assign sts_o.clr_last = (clr_q == CLR_W'(CLR_N - 1));
  assign victim_way_o   = victim_q;

endmodule
